[rtl/polyphonic_voice_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared property wrappers; clock and active-low reset are passed in.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define PVA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// ante implies cons in the same cycle
`define PVA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pva_pkg.sv]
// ----------------------------------------------------------------------------
// pva_pkg
// Types and fixed constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  // field widths
  localparam int FUNC_W    = 3;
  localparam int KEY_W     = 7;
  localparam int VEL_W     = 7;
  localparam int SEL_W     = 4;
  localparam int IDX_OUT_W = 4;
  localparam int MASK_W    = 16;
  localparam int MASK_IW   = $clog2(MASK_W);
  localparam int CNT_OUT_W = 5;
  localparam int CFG_W     = 5;

  // APB
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_VOICES_IN_USE = 3'h0;
  localparam logic [APB_AW-1:0] ADDR_VOICE_LIMIT   = 3'h4;
  localparam logic [CFG_W-1:0]  CFG_RESET          = 5'd16;

  // steal priority terms (base value is common to all voices)
  localparam int unsigned PRIO_REL  = 2000;
  localparam int unsigned PRIO_SUST = 1000;
  localparam logic [KEY_W-1:0] PEDAL_HELD = 7'd64;

  typedef enum logic [1:0] {
    ST_OFF  = 2'd0,
    ST_ON   = 2'd1,
    ST_SUST = 2'd2,
    ST_REL  = 2'd3
  } voice_status_e;

  typedef enum logic [FUNC_W-1:0] {
    FN_NOTE_ON        = 3'd0,
    FN_NOTE_OFF       = 3'd1,
    FN_PEDAL          = 3'd2,
    FN_ALL_NOTES_OFF  = 3'd3,
    FN_ALL_VOICES_OFF = 3'd4,
    FN_REL_DONE       = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_SWEEP
  } pva_state_e;

  // per-cycle control into the victim search unit
  typedef struct packed {
    logic          start;
    logic          valid;
    voice_status_e status;
  } scan_ctl_t;

endpackage

[rtl/polyphonic_voice_allocator.sv]
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator - per-event voice allocation with stealing
// Flow: note on/off, pedal and all-off requests scan the active slots, one voice per cycle,
//   then load the result register once it is free; release-done and unused codes skip the scan.
// A new request is taken only in idle, after the previous result has been loaded.
// Reset: all voices off, counters zero; a voices_in_use write runs a sweep over every voice slot.
// ----------------------------------------------------------------------------
`include "polyphonic_voice_allocator_defines.svh"

module polyphonic_voice_allocator #(
  parameter int NUM_VOICES = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pva_pkg::FUNC_W-1:0]      func_i,
  input  logic [pva_pkg::KEY_W-1:0]       key_i,
  input  logic [pva_pkg::VEL_W-1:0]       velocity_i,
  input  logic [pva_pkg::KEY_W-1:0]       pedal_i,
  input  logic [pva_pkg::SEL_W-1:0]       voice_sel_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            assigned_o,
  output logic [pva_pkg::IDX_OUT_W-1:0]   voice_index_o,
  output logic                            stolen_o,
  output logic [pva_pkg::IDX_OUT_W-1:0]   stolen_index_o,
  output logic [pva_pkg::VEL_W-1:0]       start_velocity_o,
  output logic [pva_pkg::MASK_W-1:0]      released_mask_o,
  output logic [pva_pkg::MASK_W-1:0]      sustained_mask_o,
  output logic [pva_pkg::MASK_W-1:0]      killed_mask_o,
  output logic [pva_pkg::CNT_OUT_W-1:0]   active_count_o,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pva_pkg::APB_AW-1:0]      paddr,
  input  logic [pva_pkg::APB_DW-1:0]      pwdata,
  output logic [pva_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import pva_pkg::*;

  localparam int VIW  = $clog2(NUM_VOICES);
  localparam int CntW = $clog2(NUM_VOICES + 1);
  localparam int MemW = KEY_W + STAMP_BITS;

  // one-hot mask bit for a voice; voices past the mask width are not reported
  function automatic logic [MASK_W-1:0] voice_bit(input logic [VIW-1:0] idx);
    logic [MASK_W-1:0] b;
    b = '0;
    if (32'(idx) < MASK_W) begin
      b[MASK_IW'(idx)] = 1'b1;
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic             cfg_wr, viu_wr, lim_wr;
  logic [CFG_W-1:0] viu_q, limit_q;
  logic [CntW-1:0]  scan_n;

  // Registers decode on the word address; the byte offset is ignored on write.
  assign cfg_wr = psel && penable && pwrite;
  assign viu_wr = cfg_wr && (paddr[2] == ADDR_VOICES_IN_USE[2]);
  assign lim_wr = cfg_wr && (paddr[2] == ADDR_VOICE_LIMIT[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viu_q   <= CFG_RESET;
      limit_q <= CFG_RESET;
    end else begin
      if (viu_wr) viu_q <= pwdata[CFG_W-1:0];
      if (lim_wr) limit_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (paddr)
      ADDR_VOICES_IN_USE: prdata = APB_DW'(viu_q);
      ADDR_VOICE_LIMIT:   prdata = APB_DW'(limit_q);
      default:            prdata = '0;
    endcase
  end

  // Scanned slot count, clamped to 1..NUM_VOICES
  always_comb begin
    if (viu_q == '0) begin
      scan_n = CntW'(1);
    end else if (32'(viu_q) > NUM_VOICES) begin
      scan_n = CntW'(NUM_VOICES);
    end else begin
      scan_n = CntW'(viu_q);
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  pva_state_e            state_q, state_d;
  logic [CntW-1:0]       proc_q, proc_d;       // voice under the shared unit
  logic [VIW-1:0]        proc_idx;
  logic [FUNC_W-1:0]     func_q;
  logic [KEY_W-1:0]      key_q;
  logic [VEL_W-1:0]      vel_q;
  logic [SEL_W-1:0]      sel_q;
  logic [VIW-1:0]        sel_idx;
  logic [KEY_W-1:0]      pedal_q;
  logic [STAMP_BITS-1:0] stamp_cnt_q;
  logic [CntW-1:0]       count_q, count_d;
  voice_status_e         status_q [NUM_VOICES];
  logic [NUM_VOICES-1:0] playing;

  // key and start stamp per voice; only read for voices that are playing,
  // so the store needs no clearing
  logic [MemW-1:0]       kmem [NUM_VOICES];
  logic [MemW-1:0]       rd_data_q;
  logic [VIW-1:0]        rd_addr;
  logic                  mem_we;
  logic [VIW-1:0]        mem_waddr;

  // first free voice seen during the scan
  logic                  free_found_q, free_found_d;
  logic [VIW-1:0]        free_idx_q, free_idx_d;

  // status write port, one voice per cycle
  logic                  st_we;
  logic [VIW-1:0]        st_widx;
  voice_status_e         st_wval;
  voice_status_e         old_status;

  // scan datapath
  voice_status_e         cur_status, new_status;
  logic [KEY_W-1:0]      cur_key;
  logic [STAMP_BITS-1:0] cur_stamp;
  logic                  key_hit;
  logic [CntW-1:0]       proc_nxt;

  // finish step
  logic                  accept, fin_go, use_free, steal;
  logic [VIW-1:0]        v_idx;
  logic                  vic_found;
  logic [VIW-1:0]        vic_idx;
  scan_ctl_t             vic_ctl;

  // per-request masks
  logic [MASK_W-1:0]     rel_q, rel_d, sus_q, sus_d, kill_q, kill_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic                  asg_q, stl_q;
  logic [IDX_OUT_W-1:0]  vidx_q, sidx_q;
  logic [VEL_W-1:0]      svel_q;
  logic [MASK_W-1:0]     rel_out_q, sus_out_q, kill_out_q;
  logic [CNT_OUT_W-1:0]  cnt_out_q;

  assign proc_idx   = VIW'(proc_q);
  assign sel_idx    = VIW'(sel_q);
  assign cur_status = status_q[proc_idx];
  assign cur_key    = rd_data_q[MemW-1 -: KEY_W];
  assign cur_stamp  = rd_data_q[STAMP_BITS-1:0];
  assign key_hit    = (cur_key == key_q);
  assign proc_nxt   = proc_q + CntW'(1);
  assign old_status = status_q[st_widx];

  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      playing[i] = (status_q[i] != ST_OFF);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and per-cycle control
  //   IDLE   : take a request, or start the slot sweep after a voices_in_use
  //            write (that write wins over a request in the same cycle)
  //   SCAN   : one voice per cycle through the shared unit; status update,
  //            free-voice search and victim tracking all in the same pass
  //   FINISH : start or steal a voice, or retire a released voice, then load
  //            the result register once it is free
  //   SWEEP  : turn off every playing voice at or above the scanned count
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    proc_d       = proc_q;
    in_ready_o   = 1'b0;
    accept       = 1'b0;
    fin_go       = 1'b0;
    rd_addr      = '0;
    new_status   = cur_status;
    st_we        = 1'b0;
    st_widx      = proc_idx;
    st_wval      = cur_status;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    use_free     = 1'b0;
    steal        = 1'b0;
    v_idx        = free_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = free_idx_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = !viu_wr;
        if (viu_wr) begin
          state_d = S_SWEEP;
          proc_d  = '0;
        end else if (in_valid_i) begin
          accept       = 1'b1;
          free_found_d = 1'b0;
          proc_d       = '0;
          // codes that touch every scanned voice go through the scan
          if (func_i <= FN_ALL_VOICES_OFF) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        // prefetch the next voice's key and stamp
        rd_addr = (32'(proc_nxt) < NUM_VOICES) ? VIW'(proc_nxt) : '0;
        case (func_q)
          FN_NOTE_ON: begin
            // same key already sounding gets released first
            if (key_hit && ((cur_status == ST_ON) || (cur_status == ST_SUST))) begin
              new_status = ST_REL;
            end
          end
          FN_NOTE_OFF: begin
            if ((cur_status == ST_ON) && key_hit) begin
              new_status = (pedal_q >= PEDAL_HELD) ? ST_SUST : ST_REL;
            end
          end
          FN_PEDAL: begin
            if ((pedal_q < PEDAL_HELD) && (cur_status == ST_SUST)) begin
              new_status = ST_REL;
            end
          end
          FN_ALL_NOTES_OFF: begin
            if ((cur_status == ST_ON) || (cur_status == ST_SUST)) begin
              new_status = ST_REL;
            end
          end
          FN_ALL_VOICES_OFF: begin
            new_status = ST_OFF;
          end
          default: ;
        endcase
        st_we   = (new_status != cur_status);
        st_wval = new_status;
        if ((cur_status == ST_OFF) && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = proc_idx;
        end
        if (proc_q == (scan_n - CntW'(1))) begin
          state_d = S_FINISH;
        end else begin
          proc_d = proc_nxt;
        end
      end

      S_FINISH: begin
        fin_go = !out_valid_q || out_ready_i;
        if (fin_go) begin
          state_d = S_IDLE;
          case (func_q)
            FN_NOTE_ON: begin
              // free voice only below the polyphony limit, else steal
              use_free  = free_found_q && (32'(count_q) < 32'(limit_q));
              steal     = !use_free && vic_found;
              v_idx     = use_free ? free_idx_q : vic_idx;
              st_we     = use_free || steal;
              st_widx   = v_idx;
              st_wval   = ST_ON;
              mem_we    = use_free || steal;
              mem_waddr = v_idx;
            end
            FN_REL_DONE: begin
              if ((32'(sel_q) < 32'(scan_n)) && (status_q[sel_idx] == ST_REL)) begin
                st_we   = 1'b1;
                st_widx = sel_idx;
                st_wval = ST_OFF;
              end
            end
            default: ;
          endcase
        end
      end

      S_SWEEP: begin
        if ((proc_q >= scan_n) && (cur_status != ST_OFF)) begin
          st_we   = 1'b1;
          st_wval = ST_OFF;
        end
        if (viu_wr) begin
          proc_d = '0;              // new count, sweep again from the bottom
        end else if (proc_q == CntW'(NUM_VOICES - 1)) begin
          state_d = S_IDLE;
        end else begin
          proc_d = proc_nxt;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Playing count and report masks
  // --------------------------------------------------------------------------
  always_comb begin
    count_d = count_q;
    if (st_we && (old_status == ST_OFF) && (st_wval != ST_OFF)) begin
      count_d = count_q + CntW'(1);
    end else if (st_we && (old_status != ST_OFF) && (st_wval == ST_OFF)) begin
      count_d = count_q - CntW'(1);
    end

    rel_d  = rel_q;
    sus_d  = sus_q;
    kill_d = kill_q;
    if (accept) begin
      rel_d  = '0;
      sus_d  = '0;
      kill_d = '0;
    end else begin
      // sweep kills are silent
      if (st_we && (state_q != S_SWEEP)) begin
        case (st_wval)
          ST_REL:  rel_d  = rel_q | voice_bit(st_widx);
          ST_SUST: sus_d  = sus_q | voice_bit(st_widx);
          ST_OFF:  kill_d = kill_q | voice_bit(st_widx);
          default: ;
        endcase
      end
      // a stolen voice is killed and restarted in one step
      if (steal) begin
        kill_d = kill_d | voice_bit(vic_idx);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared victim search unit
  // --------------------------------------------------------------------------
  assign vic_ctl.start  = accept;
  assign vic_ctl.valid  = (state_q == S_SCAN) && (func_q == FN_NOTE_ON);
  assign vic_ctl.status = new_status;   // priority uses the post-release state

  pva_victim_unit #(
    .NUM_VOICES (NUM_VOICES),
    .STAMP_BITS (STAMP_BITS)
  ) u_victim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (vic_ctl),
    .idx_i     (proc_idx),
    .stamp_i   (cur_stamp),
    .counter_i (stamp_cnt_q),
    .found_o   (vic_found),
    .idx_o     (vic_idx)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      proc_q       <= '0;
      count_q      <= '0;
      pedal_q      <= '0;
      stamp_cnt_q  <= '0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        status_q[i] <= ST_OFF;
      end
    end else begin
      state_q      <= state_d;
      proc_q       <= proc_d;
      count_q      <= count_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
      if (st_we) begin
        status_q[st_widx] <= st_wval;
      end
      if (accept && (func_i == FN_PEDAL)) begin
        pedal_q <= pedal_i;
      end else if (accept && (func_i == FN_ALL_NOTES_OFF)) begin
        pedal_q <= '0;
      end
      if (mem_we) begin
        stamp_cnt_q <= stamp_cnt_q + STAMP_BITS'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end
  end

  // request fields, masks and scan scratch: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= key_i;
      vel_q  <= velocity_i;
      sel_q  <= voice_sel_i;
    end
    free_idx_q <= free_idx_d;
    rel_q      <= rel_d;
    sus_q      <= sus_d;
    kill_q     <= kill_d;
  end

  // key/stamp store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      kmem[mem_waddr] <= {key_q, stamp_cnt_q};
    end
    rd_data_q <= kmem[rd_addr];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      asg_q      <= use_free || steal;
      vidx_q     <= (use_free || steal) ? IDX_OUT_W'(v_idx) : '0;
      stl_q      <= steal;
      sidx_q     <= steal ? IDX_OUT_W'(vic_idx) : '0;
      svel_q     <= (use_free || steal) ? vel_q : '0;
      rel_out_q  <= rel_d;
      sus_out_q  <= sus_d;
      kill_out_q <= kill_d;
      cnt_out_q  <= CNT_OUT_W'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign assigned_o       = asg_q;
  assign voice_index_o    = vidx_q;
  assign stolen_o         = stl_q;
  assign stolen_index_o   = sidx_q;
  assign start_velocity_o = svel_q;
  assign released_mask_o  = rel_out_q;
  assign sustained_mask_o = sus_out_q;
  assign killed_mask_o    = kill_out_q;
  assign active_count_o   = cnt_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PVA_ASSERT_ALWAYS(a_count_matches, clk_i, rst_ni,
    $countones(playing) == 32'(count_q), "playing count out of step with voice status")
  `PVA_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni,
    in_valid_i && in_ready_o, !in_ready_o, "request taken while previous one in work")
  `PVA_ASSERT_IMPLIES(a_steal_starts, clk_i, rst_ni,
    out_valid_o && stolen_o, assigned_o, "voice stolen without a voice started")

endmodule

[rtl/pva_victim_unit.sv]
// ----------------------------------------------------------------------------
// pva_victim_unit
// Shared age/priority unit: one voice per cycle, keeps the best steal victim.
// ----------------------------------------------------------------------------
module pva_victim_unit #(
  parameter int NUM_VOICES = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pva_pkg::scan_ctl_t            ctl_i,
  input  logic [$clog2(NUM_VOICES)-1:0] idx_i,
  input  logic [STAMP_BITS-1:0]         stamp_i,
  input  logic [STAMP_BITS-1:0]         counter_i,
  output logic                          found_o,
  output logic [$clog2(NUM_VOICES)-1:0] idx_o
);
  import pva_pkg::*;

  localparam int VIW    = $clog2(NUM_VOICES);
  localparam int ScoreW = ((STAMP_BITS > 11) ? STAMP_BITS : 11) + 1;

  // lowest priority == highest (age + state bonus)
  logic [STAMP_BITS-1:0] age;
  logic [ScoreW-1:0]     bonus;
  logic [ScoreW-1:0]     score;
  logic [ScoreW-1:0]     best_q, best_d;
  logic [VIW-1:0]        idx_q, idx_d;
  logic                  found_q, found_d;

  always_comb begin
    age = counter_i - stamp_i;
    case (ctl_i.status)
      ST_REL:  bonus = ScoreW'(PRIO_REL);
      ST_SUST: bonus = ScoreW'(PRIO_SUST);
      default: bonus = '0;
    endcase
    score = ScoreW'(age) + bonus;

    found_d = found_q;
    best_d  = best_q;
    idx_d   = idx_q;
    if (ctl_i.start) begin
      found_d = 1'b0;
    end else if (ctl_i.valid && (ctl_i.status != ST_OFF) &&
                 (!found_q || (score > best_q))) begin
      found_d = 1'b1;
      best_d  = score;
      idx_d   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - voice allocator testbench
// Drives note events through the request channel, predicts each result with a
// cycle-free model of the voice table, and checks every result in order while
// both channels idle and stall at random and the APB registers change setting.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pva_pkg::*;

  localparam int NV             = 16;
  localparam int PRIO_BASE      = 10000;
  localparam int PRIO_NONE      = 10001;
  // settle time before a register write: one full scan plus the clearing sweep
  localparam int CFG_PAUSE      = 40;
  localparam int END_WAIT       = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // func codes the block decodes as no-ops
  localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
    logic [KEY_W-1:0]  pedal;
    logic [SEL_W-1:0]  voice_sel;
  } note_event_t;

  typedef struct packed {
    logic                 assigned;
    logic [IDX_OUT_W-1:0] voice_index;
    logic                 stolen;
    logic [IDX_OUT_W-1:0] stolen_index;
    logic [VEL_W-1:0]     start_velocity;
    logic [MASK_W-1:0]    released_mask;
    logic [MASK_W-1:0]    sustained_mask;
    logic [MASK_W-1:0]    killed_mask;
    logic [CNT_OUT_W-1:0] active_count;
  } alloc_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i           = '0;
  logic [KEY_W-1:0]     key_i            = '0;
  logic [VEL_W-1:0]     velocity_i       = '0;
  logic [KEY_W-1:0]     pedal_i          = '0;
  logic [SEL_W-1:0]     voice_sel_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic                 assigned_o;
  logic [IDX_OUT_W-1:0] voice_index_o;
  logic                 stolen_o;
  logic [IDX_OUT_W-1:0] stolen_index_o;
  logic [VEL_W-1:0]     start_velocity_o;
  logic [MASK_W-1:0]    released_mask_o;
  logic [MASK_W-1:0]    sustained_mask_o;
  logic [MASK_W-1:0]    killed_mask_o;
  logic [CNT_OUT_W-1:0] active_count_o;
  logic                 psel             = 1'b0;
  logic                 penable          = 1'b0;
  logic                 pwrite           = 1'b0;
  logic [APB_AW-1:0]    paddr            = '0;
  logic [APB_DW-1:0]    pwdata           = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  polyphonic_voice_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .key_i            (key_i),
    .velocity_i       (velocity_i),
    .pedal_i          (pedal_i),
    .voice_sel_i      (voice_sel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .assigned_o       (assigned_o),
    .voice_index_o    (voice_index_o),
    .stolen_o         (stolen_o),
    .stolen_index_o   (stolen_index_o),
    .start_velocity_o (start_velocity_o),
    .released_mask_o  (released_mask_o),
    .sustained_mask_o (sustained_mask_o),
    .killed_mask_o    (killed_mask_o),
    .active_count_o   (active_count_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Voice table shadow. Updated at the clock edge that accepts a request or a
  // register write; the block reaches the same state only when that work ends.
  // --------------------------------------------------------------------------
  voice_status_e     vs_status [NV];
  logic [KEY_W-1:0]  vs_key    [NV];
  logic [31:0]       vs_stamp  [NV];
  logic [31:0]       stamp_ctr;
  int                playing_cnt;
  logic [KEY_W-1:0]  pedal_val;
  logic [CFG_W-1:0]  cfg_in_use;
  logic [CFG_W-1:0]  cfg_limit;
  // per-request transition masks
  logic [MASK_W-1:0] rel_acc, sus_acc, kill_acc;

  alloc_result_t     pending_results [$];
  int                mismatch_count = 0;
  int                idle_cycles    = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;

  function automatic void clear_voice_table();
    for (int i = 0; i < NV; i++) begin
      vs_status[i] = ST_OFF;
      vs_key[i]    = '0;
      vs_stamp[i]  = '0;
    end
    stamp_ctr   = '0;
    playing_cnt = 0;
    pedal_val   = '0;
    cfg_in_use  = CFG_RESET;
    cfg_limit   = CFG_RESET;
  endfunction

  function automatic int scan_len();
    if (cfg_in_use < 1) return 1;
    if (cfg_in_use > NV) return NV;
    return int'(cfg_in_use);
  endfunction

  // status change with playing-count and mask bookkeeping
  function automatic void move_voice(int i, voice_status_e s);
    if (vs_status[i] == ST_OFF && s != ST_OFF) playing_cnt++;
    else if (vs_status[i] != ST_OFF && s == ST_OFF && playing_cnt > 0) playing_cnt--;
    vs_status[i] = s;
    case (s)
      ST_REL:  rel_acc[i]  = 1'b1;
      ST_SUST: sus_acc[i]  = 1'b1;
      ST_OFF:  kill_acc[i] = 1'b1;
      default: ;
    endcase
  endfunction

  // lowest priority playing voice, first index on a tie; -1 when none plays
  function automatic int find_victim(int n);
    int          best;
    longint      min_prio;
    longint      prio;
    logic [31:0] age;
    best     = -1;
    min_prio = PRIO_NONE;
    for (int i = 0; i < n; i++) begin
      if (vs_status[i] != ST_OFF) begin
        age  = stamp_ctr - vs_stamp[i];
        prio = PRIO_BASE;
        if (vs_status[i] == ST_REL) prio = prio - longint'(PRIO_REL);
        else if (vs_status[i] == ST_SUST) prio = prio - longint'(PRIO_SUST);
        prio = prio - longint'(age);
        if (prio < min_prio) begin
          min_prio = prio;
          best     = i;
        end
      end
    end
    return best;
  endfunction

  function automatic alloc_result_t allocate_voice(note_event_t ev);
    alloc_result_t r;
    int            n;
    int            v;
    r        = '0;
    rel_acc  = '0;
    sus_acc  = '0;
    kill_acc = '0;
    n        = scan_len();
    v        = -1;
    case (ev.func)
      FN_NOTE_ON: begin
        // retrigger: same key voices that still sound go to release first
        for (int i = 0; i < n; i++)
          if (vs_key[i] == ev.key && (vs_status[i] == ST_ON || vs_status[i] == ST_SUST))
            move_voice(i, ST_REL);
        if (playing_cnt < int'(cfg_limit))
          for (int i = 0; i < n; i++)
            if (v < 0 && vs_status[i] == ST_OFF) v = i;
        if (v < 0) begin
          v = find_victim(n);
          if (v >= 0) begin
            move_voice(v, ST_OFF);
            r.stolen       = 1'b1;
            r.stolen_index = 4'(v);
          end
        end
        if (v >= 0) begin
          move_voice(v, ST_ON);
          vs_key[v]        = ev.key;
          vs_stamp[v]      = stamp_ctr;
          stamp_ctr        = stamp_ctr + 32'd1;
          r.assigned       = 1'b1;
          r.voice_index    = 4'(v);
          r.start_velocity = ev.velocity;
        end
      end
      FN_NOTE_OFF: begin
        for (int i = 0; i < n; i++)
          if (vs_status[i] == ST_ON && vs_key[i] == ev.key) begin
            if (pedal_val >= PEDAL_HELD) move_voice(i, ST_SUST);
            else move_voice(i, ST_REL);
          end
      end
      FN_PEDAL: begin
        pedal_val = ev.pedal;
        if (ev.pedal < PEDAL_HELD)
          for (int i = 0; i < n; i++)
            if (vs_status[i] == ST_SUST) move_voice(i, ST_REL);
      end
      FN_ALL_NOTES_OFF: begin
        pedal_val = '0;
        for (int i = 0; i < n; i++)
          if (vs_status[i] == ST_ON || vs_status[i] == ST_SUST) move_voice(i, ST_REL);
      end
      FN_ALL_VOICES_OFF: begin
        for (int i = 0; i < n; i++)
          if (vs_status[i] != ST_OFF) move_voice(i, ST_OFF);
      end
      FN_REL_DONE: begin
        if (int'(ev.voice_sel) < n && vs_status[ev.voice_sel] == ST_REL)
          move_voice(int'(ev.voice_sel), ST_OFF);
      end
      default: ;
    endcase
    r.released_mask  = rel_acc;
    r.sustained_mask = sus_acc;
    r.killed_mask    = kill_acc;
    r.active_count   = 5'(playing_cnt);
    return r;
  endfunction

  // shrinking the scan range silences the voices above it
  function automatic void apply_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    if (addr == ADDR_VOICES_IN_USE) begin
      cfg_in_use = data[CFG_W-1:0];
      for (int i = scan_len(); i < NV; i++)
        if (vs_status[i] != ST_OFF) move_voice(i, ST_OFF);
    end else if (addr == ADDR_VOICE_LIMIT) begin
      cfg_limit = data[CFG_W-1:0];
    end
  endfunction

  task automatic report_mismatch(string what, alloc_result_t want, alloc_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: exp asg=%0d vi=%0d stl=%0d si=%0d vel=%0d rel=%h sus=%h kill=%h cnt=%0d",
               $realtime, what, want.assigned, want.voice_index, want.stolen,
               want.stolen_index, want.start_velocity, want.released_mask,
               want.sustained_mask, want.killed_mask, want.active_count);
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: got asg=%0d vi=%0d stl=%0d si=%0d vel=%0d rel=%h sus=%h kill=%h cnt=%0d",
               $realtime, what, got.assigned, got.voice_index, got.stolen,
               got.stolen_index, got.start_velocity, got.released_mask,
               got.sustained_mask, got.killed_mask, got.active_count);
  endtask

  // --------------------------------------------------------------------------
  // Edge monitor: register writes, then accepted requests, then results, all
  // in one process so the shadow and the queue see a fixed order per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    bit            progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (psel && penable && pwrite && pready) begin
        apply_register(paddr, pwdata);
        progress = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(allocate_voice(
          note_event_t'({func_i, key_i, velocity_i, pedal_i, voice_sel_i})));
        progress = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        got = alloc_result_t'({assigned_o, voice_index_o, stolen_o, stolen_index_o,
                               start_velocity_o, released_mask_o, sustained_mask_o,
                               killed_mask_o, active_count_o});
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
    end
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // no handshake of any kind for too long ends the run
  initial begin
    wait (rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver. Valid is either re-driven with a new request or dropped
  // for an idle cycle at each falling edge, never both in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(note_event_t ev);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= ev.func;
    key_i       <= ev.key;
    velocity_i  <= ev.velocity;
    pedal_i     <= ev.pedal;
    voice_sel_i <= ev.voice_sel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic note_event_t mk(logic [FUNC_W-1:0] func, int key, int vel,
                                     int ped, int sel);
    note_event_t ev;
    ev.func      = func;
    ev.key       = 7'(key);
    ev.velocity  = 7'(vel);
    ev.pedal     = 7'(ped);
    ev.voice_sel = 4'(sel);
    return ev;
  endfunction

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // writes happen only with the block idle and any clearing sweep finished
  task automatic configure(int in_use, int limit);
    drain_results();
    repeat (CFG_PAUSE) @(negedge clk_i);
    apb_write(ADDR_VOICES_IN_USE, in_use);
    repeat (CFG_PAUSE) @(negedge clk_i);
    apb_write(ADDR_VOICE_LIMIT, limit);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // reset setting: key and velocity extremes, retrigger, release done, no-ops
  task automatic test_note_on_basics();
    send_request(mk(FN_NOTE_ON,     0,   0,   0,  0));
    send_request(mk(FN_NOTE_ON,   127, 127, 127, 15));
    // same key again releases voice 0 and starts a fresh voice
    send_request(mk(FN_NOTE_ON,     0,  64,   0,  0));
    send_request(mk(FN_NOTE_OFF,  127,   0,   0,  0));
    send_request(mk(FN_REL_DONE,    0,   0,   0,  1));
    // release done on a voice that is still on: no change
    send_request(mk(FN_REL_DONE,    0,   0,   0,  2));
    send_request(mk(FN_UNUSED_6,  127, 127, 127, 15));
    send_request(mk(FN_UNUSED_7,   85,  42,  21, 10));
  endtask

  // pedal threshold at 63/64, note off into sustain, retrigger of sustained
  task automatic test_sustain_pedal();
    send_request(mk(FN_PEDAL,       0,   0,  64,  0));
    send_request(mk(FN_NOTE_ON,    60, 100,   0,  0));
    send_request(mk(FN_NOTE_OFF,   60,   0,   0,  0));
    send_request(mk(FN_NOTE_ON,    60,  90,   0,  0));
    send_request(mk(FN_NOTE_OFF,   60,   0,   0,  0));
    send_request(mk(FN_PEDAL,       0,   0,  63,  0));
  endtask

  task automatic test_bulk_off();
    send_request(mk(FN_PEDAL,       0,   0, 127,  0));
    // all notes off also drops the pedal
    send_request(mk(FN_ALL_NOTES_OFF, 0, 0,   0,  0));
    send_request(mk(FN_ALL_VOICES_OFF, 0, 0,  0,  0));
  endtask

  task automatic test_voice_stealing();
    // limit of two: third note steals the oldest, then a released voice wins
    configure(16, 2);
    send_request(mk(FN_NOTE_ON,    20,  10,   0,  0));
    send_request(mk(FN_NOTE_ON,    21,  20,   0,  0));
    send_request(mk(FN_NOTE_ON,    22,  30,   0,  0));
    send_request(mk(FN_NOTE_OFF,   21,   0,   0,  0));
    send_request(mk(FN_NOTE_ON,    23,  40,   0,  0));
    // single slot: release done outside the range is ignored, and a retrigger
    // releases and steals the same voice in one request
    configure(1, 16);
    send_request(mk(FN_REL_DONE,    0,   0,   0, 15));
    send_request(mk(FN_NOTE_ON,    30,  50,   0,  0));
    send_request(mk(FN_NOTE_ON,    30,  60,   0,  0));
    // zero limit with nothing playing: stealing finds no victim
    configure(16, 0);
    send_request(mk(FN_ALL_VOICES_OFF, 0, 0,  0,  0));
    send_request(mk(FN_NOTE_ON,    40,  70,   0,  0));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly note on/off over a narrow key window so retriggers,
  // stealing and pedal transitions happen often; release-done requests mostly
  // target voices that are actually in release so slots free up again.
  // --------------------------------------------------------------------------
  function automatic note_event_t random_event(logic [KEY_W-1:0] key_base);
    note_event_t ev;
    int          roll;
    int          cand [$];
    ev.func      = FN_NOTE_ON;
    ev.key       = 7'($urandom_range(127));
    ev.velocity  = 7'($urandom_range(127));
    ev.pedal     = 7'($urandom_range(127));
    ev.voice_sel = 4'($urandom_range(15));
    if ($urandom_range(9) != 0) ev.key = key_base + 7'($urandom_range(11));
    roll = $urandom_range(99);
    if (roll < 42) begin
      ev.func = FN_NOTE_ON;
    end else if (roll < 64) begin
      ev.func = FN_NOTE_OFF;
      for (int i = 0; i < NV; i++) if (vs_status[i] == ST_ON) cand.push_back(i);
      if (cand.size() != 0 && $urandom_range(3) != 0)
        ev.key = vs_key[cand[$urandom_range(cand.size() - 1)]];
    end else if (roll < 74) begin
      ev.func  = FN_PEDAL;
      ev.pedal = $urandom_range(1) ? 7'(64 + $urandom_range(63)) : 7'($urandom_range(63));
    end else if (roll < 90) begin
      ev.func = FN_REL_DONE;
      for (int i = 0; i < NV; i++) if (vs_status[i] == ST_REL) cand.push_back(i);
      if (cand.size() != 0 && $urandom_range(3) != 0)
        ev.voice_sel = 4'(cand[$urandom_range(cand.size() - 1)]);
    end else if (roll < 94) begin
      ev.func = FN_ALL_NOTES_OFF;
    end else if (roll < 96) begin
      ev.func = FN_ALL_VOICES_OFF;
    end else begin
      ev.func = $urandom_range(1) ? FN_UNUSED_7 : FN_UNUSED_6;
    end
    return ev;
  endfunction

  task automatic test_random_traffic(int items, int idle_pct, int stall_pct,
                                     int in_use, int limit);
    note_event_t      ev;
    logic [KEY_W-1:0] key_base;
    int               sent;
    configure(in_use, limit);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    key_base       = 7'($urandom_range(127));
    sent           = 0;
    while (sent < items) begin
      ev = random_event(key_base);
      send_request(ev);
      // no-op codes do not count as traffic
      if (ev.func != FN_UNUSED_6 && ev.func != FN_UNUSED_7) sent++;
      if (sent % 30 == 29) key_base = 7'($urandom_range(127));
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_voice_table();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_note_on_basics();
    test_sustain_pedal();
    test_bulk_off();
    test_voice_stealing();

    // idling phases, two register settings each, extremes included
    test_random_traffic(105,  0,  0, 16, 16);
    test_random_traffic(105,  0,  0,  1,  1);
    test_random_traffic(105, 46,  0, 16,  4);
    test_random_traffic(105, 46,  0, $urandom_range(1, 16), $urandom_range(1, 16));
    test_random_traffic(105,  0, 46,  8, 16);
    test_random_traffic(105,  0, 46, 16,  1);
    test_random_traffic(105, 17, 17,  1, 16);
    test_random_traffic(105, 17, 17, $urandom_range(1, 16), $urandom_range(1, 16));

    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[polyphonic_voice_allocator.f]
+incdir+rtl
rtl/pva_pkg.sv
rtl/pva_victim_unit.sv
rtl/polyphonic_voice_allocator.sv
sim/tb_top.sv
